@@ rtl/dsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline slot allocator package
// Shared constants, stream word widths, microcode word format and the
// control program of the slot allocator sequencer.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int FIELD_W           = 9;
  localparam int MAX_SLOTS_DEFAULT = 256;
  localparam int S_TDATA_W         = 24;
  localparam int M_TDATA_W         = 16;
  localparam logic [FIELD_W-1:0] SLOTS_RESET = 9'd256;

  localparam logic ACTION_CLAIM = 1'b0;
  localparam logic ACTION_CLEAR = 1'b1;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_INIT_WIPE = 3'd0;
  localparam step_t STEP_IDLE      = 3'd1;
  localparam step_t STEP_DISPATCH  = 3'd2;
  localparam step_t STEP_SCAN      = 3'd3;
  localparam step_t STEP_POST      = 3'd4;
  localparam step_t STEP_WIPE      = 3'd5;

  typedef logic [2:0] cond_t;

  localparam cond_t COND_ACCEPT    = 3'd0;
  localparam cond_t COND_CLEAR     = 3'd1;
  localparam cond_t COND_SWEEP_END = 3'd2;
  localparam cond_t COND_SCAN_END  = 3'd3;
  localparam cond_t COND_OUT_FREE  = 3'd4;

  typedef struct packed {
    logic  ready;
    logic  load;
    logic  sweep;
    logic  scan;
    logic  post;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } ctrl_word_t;

  typedef struct packed {
    logic accept;
    logic is_clear;
    logic sweep_end;
    logic scan_end;
    logic out_free;
  } cond_flags_t;

  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t w;
    w = '0;
    unique case (step)
      STEP_INIT_WIPE: begin
        w.sweep = 1'b1;
        w.cond = COND_SWEEP_END;
        w.tgt_true = STEP_IDLE;
        w.tgt_false = STEP_INIT_WIPE;
      end
      STEP_IDLE: begin
        w.ready = 1'b1;
        w.cond = COND_ACCEPT;
        w.tgt_true = STEP_DISPATCH;
        w.tgt_false = STEP_IDLE;
      end
      STEP_DISPATCH: begin
        w.load = 1'b1;
        w.cond = COND_CLEAR;
        w.tgt_true = STEP_WIPE;
        w.tgt_false = STEP_SCAN;
      end
      STEP_SCAN: begin
        w.scan = 1'b1;
        w.cond = COND_SCAN_END;
        w.tgt_true = STEP_POST;
        w.tgt_false = STEP_SCAN;
      end
      STEP_POST: begin
        w.post = 1'b1;
        w.cond = COND_OUT_FREE;
        w.tgt_true = STEP_IDLE;
        w.tgt_false = STEP_POST;
      end
      STEP_WIPE: begin
        w.sweep = 1'b1;
        w.cond = COND_SWEEP_END;
        w.tgt_true = STEP_POST;
        w.tgt_false = STEP_WIPE;
      end
      default: begin
        w.cond = COND_ACCEPT;
        w.tgt_true = STEP_IDLE;
        w.tgt_false = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/dsa_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline slot allocator sequencer
// Step counter over the control program, with a conditional jump per step.
// ----------------------------------------------------------------------------
module dsa_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  dsa_pkg::cond_flags_t flags,
  output dsa_pkg::ctrl_word_t  ctrl
);
  import dsa_pkg::*;

  step_t upc;
  step_t upc_next;
  logic  taken;

  assign ctrl = ucode_rom(upc);

  always_comb begin
    unique case (ctrl.cond)
      COND_ACCEPT:    taken = flags.accept;
      COND_CLEAR:     taken = flags.is_clear;
      COND_SWEEP_END: taken = flags.sweep_end;
      COND_SCAN_END:  taken = flags.scan_end;
      COND_OUT_FREE:  taken = flags.out_free;
      default:        taken = 1'b0;
    endcase
    upc_next = taken ? ctrl.tgt_true : ctrl.tgt_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_INIT_WIPE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

@@ rtl/deadline_slot_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline slot allocator
// Slot map with claim and clear requests, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// The block handles one request at a time. The slot map is a one-bit memory
// with a single read and a single write per cycle, and the scan reads one slot
// per cycle from the latest allowed slot downward. A claim scans down from the
// clamped deadline and ends early when the requested count is reached. A clear
// request rewrites every entry of the map, one per cycle. Either takes longer
// while the previous result word still waits for m_tready. After reset the
// same clearing pass runs before s_tready rises; configuration writes are taken
// at any time.
module deadline_slot_allocator_unit #(
  parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // request_count [8:0], deadline [17:9], zero padding above.
  input  logic [dsa_pkg::S_TDATA_W-1:0] s_tdata,
  // action [0].
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // granted [8:0], zero padding above.
  output logic [dsa_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dsa_pkg::FIELD_W-1:0]   cfg_data
);
  import dsa_pkg::*;

  localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int RW     = ((ADDR_W > FIELD_W) ? ADDR_W : FIELD_W) + 1;

  ctrl_word_t  ctrl;
  cond_flags_t flags;

  logic [FIELD_W-1:0] slots_in_use;
  logic               act;
  logic [FIELD_W-1:0] want;
  logic [FIELD_W-1:0] dl;
  logic [FIELD_W-1:0] given;
  logic [FIELD_W-1:0] given_next;
  logic [RW-1:0]      rem;
  logic [RW-1:0]      rem_m1;
  logic [RW-1:0]      limit;
  logic [RW-1:0]      eff_dl;
  logic [ADDR_W-1:0]  pend_addr;
  logic               pend_valid;
  logic               rd_data;
  logic               issue;
  logic               grant;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic               out_free;
  logic [FIELD_W-1:0] out_data;

  logic slot_free [MAX_SLOTS];

  dsa_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign s_tready  = ctrl.ready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = M_TDATA_W'(out_data);
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    limit  = (RW'(slots_in_use) > RW'(MAX_SLOTS)) ? RW'(MAX_SLOTS) : RW'(slots_in_use);
    eff_dl = (RW'(dl) > limit) ? limit : RW'(dl);
    rem_m1 = rem - RW'(1);
    issue  = ctrl.scan && (rem != '0);
    grant  = ctrl.scan && pend_valid && rd_data && (given != want);
    given_next = given + FIELD_W'(grant);
    wr_en   = ctrl.sweep || grant;
    wr_addr = ctrl.sweep ? rem_m1[ADDR_W-1:0] : pend_addr;

    flags.accept    = s_tvalid && s_tready;
    flags.is_clear  = (act == ACTION_CLEAR);
    flags.sweep_end = (rem == RW'(1));
    flags.scan_end  = (given_next == want) || (rem == '0);
    flags.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_free[wr_addr] <= ctrl.sweep;
    end
    if (issue) begin
      rd_data <= slot_free[rem_m1[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (flags.accept) begin
      act  <= s_tuser;
      want <= s_tdata[FIELD_W-1:0];
      dl   <= s_tdata[2*FIELD_W-1:FIELD_W];
    end
    if (issue) begin
      pend_addr <= rem_m1[ADDR_W-1:0];
    end
    if (ctrl.load) begin
      given <= '0;
    end else if (ctrl.scan) begin
      given <= given_next;
    end
    if (ctrl.post && out_free) begin
      out_data <= given;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_RESET;
      rem          <= RW'(MAX_SLOTS);
      pend_valid   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slots_in_use <= cfg_data;
      end
      if (ctrl.load) begin
        rem <= flags.is_clear ? RW'(MAX_SLOTS) : eff_dl;
      end else if (ctrl.sweep || issue) begin
        rem <= rem_m1;
      end
      pend_valid <= issue;
      if (ctrl.post && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/dsa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline slot allocator checker
// Port-level checks of the allocator's stream behavior, bound to the top.
// ----------------------------------------------------------------------------
module dsa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [dsa_pkg::M_TDATA_W-1:0] m_tdata
);
  import dsa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result word changed or dropped while stalled.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input accepted while a request was still in work.");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("Result word appeared without a request in work.");

  a_reset_quiet: assert property (@(posedge clk)
    $fell(rst) |-> !s_tready && !m_tvalid)
    else $error("Block not quiet while the slot map is being cleared.");

endmodule

bind deadline_slot_allocator_unit dsa_checker u_dsa_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline slot allocator testbench
// Streams claim and clear requests into the slot allocator under several slot
// counts and idling patterns, tracks the slot map on the side and checks every
// granted count against the one worked out for its request.
// ----------------------------------------------------------------------------
module tb;
  import dsa_pkg::*;

  localparam int MAP_SLOTS        = 256;
  localparam int SETTLE_CYCLES    = 8;
  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 210;
  localparam int LONG_HOLD_AT     = 60;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic               action;
    logic [FIELD_W-1:0] request_count;
    logic [FIELD_W-1:0] deadline;
  } slot_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = ACTION_CLAIM;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [FIELD_W-1:0]   cfg_data = '0;

  slot_req_t            pending_q[$];
  logic [FIELD_W-1:0]   grant_q[$];
  slot_req_t            offered;
  logic [MAP_SLOTS-1:0] slot_free = '1;
  logic [FIELD_W-1:0]   slot_limit = SLOTS_RESET;
  int                   send_idle_pct = 0;
  int                   sink_stall_pct = 0;
  int                   pushed_total = 0;
  int                   results_seen = 0;
  int                   accepted_items = 0;
  int                   failures = 0;
  int                   hold_left = 0;
  logic                 hold_done = 1'b0;

  deadline_slot_allocator_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Applies one request to the shadow slot map and returns the granted count.
  function automatic logic [FIELD_W-1:0] claim_slots(input slot_req_t req);
    int unsigned span;
    int unsigned got;
    if (req.action == ACTION_CLEAR) begin
      slot_free = '1;
      return '0;
    end
    span = (slot_limit > MAP_SLOTS) ? MAP_SLOTS : slot_limit;
    if (req.deadline < span) begin
      span = req.deadline;
    end
    got = 0;
    for (int i = span; i > 0 && got < req.request_count; i--) begin
      if (slot_free[i-1]) begin
        slot_free[i-1] = 1'b0;
        got++;
      end
    end
    return FIELD_W'(got);
  endfunction

  function automatic slot_req_t random_request(input int unsigned slots);
    slot_req_t r;
    int unsigned span;
    int unsigned pick;
    span = (slots > MAP_SLOTS) ? MAP_SLOTS : slots;
    pick = $urandom_range(99);
    r.action = ACTION_CLAIM;
    r.request_count = FIELD_W'($urandom_range(1, 12));
    r.deadline = (span == 0) ? FIELD_W'($urandom_range(1, 511))
                             : FIELD_W'($urandom_range(1, span));
    if (pick < 4) begin
      r.action = ACTION_CLEAR;
      r.request_count = FIELD_W'($urandom_range(0, 511));
      r.deadline = FIELD_W'($urandom_range(0, 511));
    end else if (pick < 8) begin
      r.request_count = '0;
    end else if (pick < 12) begin
      r.deadline = '0;
    end else if (pick < 18) begin
      r.deadline = FIELD_W'($urandom_range(0, 511));
    end else if (pick < 24) begin
      r.request_count = FIELD_W'($urandom_range(0, 511));
    end
    return r;
  endfunction

  task automatic queue_request(input logic act, input int unsigned cnt,
                               input int unsigned dl);
    slot_req_t r;
    r.action = act;
    r.request_count = FIELD_W'(cnt);
    r.deadline = FIELD_W'(dl);
    pending_q.push_back(r);
    pushed_total++;
  endtask

  task automatic wait_drained();
    while (results_seen < pushed_total) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [FIELD_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    slot_limit = value;
  endtask

  always @(posedge clk) begin : request_feed
    logic offering;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      offering = s_tvalid;
      if (s_tvalid && s_tready) begin
        grant_q.push_back(claim_slots(offered));
        accepted_items <= accepted_items + 1;
        offering = 1'b0;
      end
      if (!offering && pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = pending_q.pop_front();
        s_tdata <= S_TDATA_W'({offered.deadline, offered.request_count});
        s_tuser <= offered.action;
        offering = 1'b1;
      end
      s_tvalid <= offering;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && accepted_items == LONG_HOLD_AT) begin
      hold_left <= LONG_HOLD_CYCLES;
      hold_done <= 1'b1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : grant_check
    logic [FIELD_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (grant_q.size() == 0) begin
        $error("granted word with no request outstanding: %0d", m_tdata[FIELD_W-1:0]);
        failures <= failures + 1;
      end else begin
        want = grant_q.pop_front();
        if (m_tdata[FIELD_W-1:0] !== want) begin
          $error("granted mismatch: expected %0d, actual %0d", want, m_tdata[FIELD_W-1:0]);
          failures <= failures + 1;
        end
      end
    end
  end

  initial begin
    int unsigned slots;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset slot count, zero fields, full map and clamped deadlines.
    queue_request(ACTION_CLAIM, 0, 256);
    queue_request(ACTION_CLAIM, 5, 0);
    queue_request(ACTION_CLAIM, 1, 256);
    queue_request(ACTION_CLAIM, 511, 511);
    queue_request(ACTION_CLAIM, 1, 256);
    queue_request(ACTION_CLEAR, 511, 511);
    queue_request(ACTION_CLAIM, 3, 1);
    queue_request(ACTION_CLAIM, 256, 256);
    queue_request(ACTION_CLEAR, 0, 0);
    queue_request(ACTION_CLAIM, 9'h155, 9'h0AA);
    queue_request(ACTION_CLAIM, 9'h0AA, 9'h155);
    wait_drained();

    // A zero slot count grants nothing.
    write_slot_count(9'd0);
    queue_request(ACTION_CLAIM, 10, 10);
    queue_request(ACTION_CLAIM, 511, 511);
    wait_drained();

    // A slot count above the map saturates.
    write_slot_count(9'd511);
    queue_request(ACTION_CLEAR, 0, 0);
    queue_request(ACTION_CLAIM, 300, 300);
    wait_drained();

    // A single slot, then a write that must leave the map alone.
    write_slot_count(9'd1);
    queue_request(ACTION_CLEAR, 0, 0);
    queue_request(ACTION_CLAIM, 4, 300);
    queue_request(ACTION_CLAIM, 1, 1);
    wait_drained();
    write_slot_count(9'd256);
    queue_request(ACTION_CLAIM, 2, 256);
    queue_request(ACTION_CLAIM, 300, 1);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 62; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 62; end
        default: begin send_idle_pct = 10; sink_stall_pct = 10; end
      endcase
      case (p)
        0: slots = 256;
        1: slots = 1;
        2: slots = 16;
        3: slots = 511;
        4: slots = 0;
        5: slots = 37;
        6: slots = 200;
        default: slots = 256;
      endcase
      write_slot_count(FIELD_W'(slots));
      queue_request(ACTION_CLEAR, 0, 0);
      repeat (ITEMS_PER_PHASE) begin
        pending_q.push_back(random_request(slots));
        pushed_total++;
      end
      wait_drained();
    end

    if (failures == 0 && grant_q.size() == 0) begin
      $display("deadline_slot_allocator_unit verification clean");
    end else begin
      if (grant_q.size() != 0) begin
        $error("%0d granted words never arrived", grant_q.size());
      end
      $display("deadline_slot_allocator_unit verification failed");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("deadline_slot_allocator_unit verification failed");
    $finish;
  end

endmodule
